[sv/dtti_pkg.sv]
// shared types and constants of the decimal text to integer core
// used by every module of the block; depends on nothing

package dtti_pkg;

    // magnitude width and derived widths
    localparam int VALUE_BITS     = 32;
    localparam int OUT_BITS       = 33;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;
    localparam int SUM_BITS       = VALUE_BITS + 4;
    localparam int CALC_BITS      = (VALUE_BITS + 1 > OUT_BITS) ? VALUE_BITS + 1 : OUT_BITS;

    // queue between front and back, a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // number modes
    localparam logic MODE_SIGNED   = 1'b0;
    localparam logic MODE_UNSIGNED = 1'b1;

    // character classes found by the front
    typedef enum logic [2:0] {
        CLS_BLANK,
        CLS_PLUS,
        CLS_MINUS,
        CLS_DIGIT,
        CLS_OTHER
    } t_char_class;

    // one classified request travelling through the queue
    typedef struct packed {
        t_char_class cls;
        logic [3:0]  digit;
        logic        mode;
        logic        last;
    } t_q_entry;

endpackage

[sv/decimal_text_to_integer_core.sv]
// top level of the decimal text to integer core
// depends on dtti_pkg, dtti_front, dtti_queue and dtti_back
//
// Input stream: one character per request in i_s_tdata, i_s_tlast on the final
// character of a string. Output stream: one request per string, o_m_tuser is the
// ok flag and o_m_tdata the 33-bit value (two's complement, zero on failure).
// i_cfg_wr_en with i_cfg_wr_data writes the number mode: 0 signed with an optional
// leading sign, 1 unsigned without sign. Write it only while no string is in flight.
// Throughput is one character per cycle while the queue has room; the digit step (times
// ten plus digit and the limit compare) is one adder and comparator in the back end.
// Result path: the last character is written into the two-entry queue when it is
// taken and moves into the result register when it leaves the queue head; o_m_tvalid
// rises once the result register is loaded.
// Reset clears the mode to signed, empties the queue and clears the scan state.
// When the receiver stalls the result holds; characters that are not last keep
// being consumed, a last character waits at the queue head, and o_s_tready falls
// once the queue holds two characters.

module decimal_text_to_integer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_wr_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [7:0]                          i_s_tdata,    // [7:0] text_byte
    input  logic                                i_s_tlast,    // last_byte
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [dtti_pkg::OUT_TDATA_BITS-1:0] o_m_tdata,    // [32:0] number_value, rest zero
    output logic                                o_m_tuser     // parse_ok
);

    dtti_pkg::t_q_entry            l_push_entry;
    dtti_pkg::t_q_entry            l_head;
    logic                          l_push;
    logic                          l_pop;
    logic                          l_full;
    logic                          l_empty;
    logic [dtti_pkg::OUT_BITS-1:0] l_value;

    // classify characters
    dtti_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_s_tvalid),
        .i_text_byte   (i_s_tdata),
        .i_last_byte   (i_s_tlast),
        .i_q_full      (l_full),
        .o_push        (l_push),
        .o_entry       (l_push_entry)
    );

    // decouple front and back
    dtti_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (l_push),
        .i_push_entry (l_push_entry),
        .i_pop        (l_pop),
        .o_full       (l_full),
        .o_empty      (l_empty),
        .o_head       (l_head)
    );

    // scan, accumulate and emit
    dtti_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (l_empty),
        .i_head         (l_head),
        .o_pop          (l_pop),
        .o_out_valid    (o_m_tvalid),
        .i_out_ready    (i_m_tready),
        .o_parse_ok     (o_m_tuser),
        .o_number_value (l_value)
    );

    assign o_s_tready = !l_full;
    assign o_m_tdata  = dtti_pkg::OUT_TDATA_BITS'(l_value);

endmodule

[sv/dtti_front.sv]
// front of the decimal text to integer core: mode register and character classifier
// depends on dtti_pkg

module dtti_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    input  logic               i_valid,
    input  logic [7:0]         i_text_byte,
    input  logic               i_last_byte,
    input  logic               i_q_full,
    output logic               o_push,
    output dtti_pkg::t_q_entry o_entry
);

    logic       r_number_mode;
    logic [7:0] l_diff;

    // number mode register, kept across strings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_mode <= dtti_pkg::MODE_SIGNED;
        end else if (i_cfg_wr_en) begin
            r_number_mode <= i_cfg_wr_data;
        end
    end

    // classify the incoming byte
    assign l_diff = i_text_byte - dtti_pkg::CH_ZERO;

    always_comb begin
        o_entry.digit = l_diff[3:0];
        o_entry.mode  = r_number_mode;
        o_entry.last  = i_last_byte;
        case (i_text_byte) inside
            dtti_pkg::CH_SPACE,
            [dtti_pkg::CH_TAB:dtti_pkg::CH_CR]:   o_entry.cls = dtti_pkg::CLS_BLANK;
            dtti_pkg::CH_PLUS:                    o_entry.cls = dtti_pkg::CLS_PLUS;
            dtti_pkg::CH_MINUS:                   o_entry.cls = dtti_pkg::CLS_MINUS;
            [dtti_pkg::CH_ZERO:dtti_pkg::CH_NINE]: o_entry.cls = dtti_pkg::CLS_DIGIT;
            default:                              o_entry.cls = dtti_pkg::CLS_OTHER;
        endcase
    end

    // request enters the queue whenever there is room
    assign o_push = i_valid && !i_q_full;

endmodule

[sv/dtti_queue.sv]
// short register queue between front and back of the decimal text to integer core
// depends on dtti_pkg

module dtti_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  dtti_pkg::t_q_entry i_push_entry,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output dtti_pkg::t_q_entry o_head
);

    dtti_pkg::t_q_entry r_entries [dtti_pkg::QUEUE_DEPTH];
    logic [dtti_pkg::QPTR_BITS-1:0] r_wr_ptr;
    logic [dtti_pkg::QPTR_BITS-1:0] r_rd_ptr;
    logic [dtti_pkg::QCNT_BITS-1:0] r_count;

    // entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_push_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == dtti_pkg::QCNT_BITS'(dtti_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_entries[r_rd_ptr];

endmodule

[sv/dtti_back.sv]
// back of the decimal text to integer core: scan state, accumulator, limit check
// and the result register; depends on dtti_pkg

module dtti_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_empty,
    input  dtti_pkg::t_q_entry              i_head,
    output logic                            o_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_parse_ok,
    output logic [dtti_pkg::OUT_BITS-1:0]   o_number_value
);

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_SIGN,
        PH_DIGIT,
        PH_TRAIL
    } t_phase;

    t_phase                           r_phase,  n_phase;
    logic [dtti_pkg::VALUE_BITS-1:0]  r_acc,    n_acc;
    logic                             r_neg,    n_neg;
    logic                             r_failed, n_failed;
    logic                             r_out_valid, n_out_valid;
    logic                             r_out_ok,    n_out_ok;
    logic [dtti_pkg::OUT_BITS-1:0]    r_out_value, n_out_value;

    logic [dtti_pkg::SUM_BITS-1:0]    l_acc_ext;
    logic [dtti_pkg::SUM_BITS-1:0]    l_sum;
    logic [dtti_pkg::SUM_BITS-1:0]    l_half;
    logic [dtti_pkg::SUM_BITS-1:0]    l_limit;
    logic [dtti_pkg::CALC_BITS-1:0]   l_mag;
    logic [dtti_pkg::CALC_BITS-1:0]   l_signed;
    logic                             l_ok;

    // a last request waits until the result register is free
    assign o_pop = !i_q_empty && (!i_head.last || !r_out_valid || i_out_ready);

    // times ten plus digit, and the limit for the current mode and sign
    assign l_acc_ext = dtti_pkg::SUM_BITS'(r_acc);
    assign l_sum     = (l_acc_ext << 3) + (l_acc_ext << 1)
                     + dtti_pkg::SUM_BITS'(i_head.digit);
    assign l_half    = dtti_pkg::SUM_BITS'(1) << (dtti_pkg::VALUE_BITS - 1);

    always_comb begin
        if (i_head.mode == dtti_pkg::MODE_UNSIGNED) begin
            l_limit = (l_half << 1) - 1'b1;
        end else if (r_neg) begin
            l_limit = l_half;
        end else begin
            l_limit = l_half - 1'b1;
        end
    end

    // scan step for the head request
    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_failed = r_failed;
        if (!r_failed) begin
            case (i_head.cls)
                dtti_pkg::CLS_BLANK: begin
                    if (r_phase == PH_SIGN) begin
                        n_failed = 1'b1;
                    end else if (r_phase == PH_DIGIT) begin
                        n_phase = PH_TRAIL;
                    end
                end
                dtti_pkg::CLS_PLUS,
                dtti_pkg::CLS_MINUS: begin
                    if (r_phase != PH_LEAD || i_head.mode == dtti_pkg::MODE_UNSIGNED) begin
                        n_failed = 1'b1;
                    end else begin
                        n_neg   = (i_head.cls == dtti_pkg::CLS_MINUS);
                        n_phase = PH_SIGN;
                    end
                end
                dtti_pkg::CLS_DIGIT: begin
                    if (r_phase == PH_TRAIL || l_sum > l_limit) begin
                        n_failed = 1'b1;
                    end else begin
                        n_acc   = l_sum[dtti_pkg::VALUE_BITS-1:0];
                        n_phase = PH_DIGIT;
                    end
                end
                default: begin
                    n_failed = 1'b1;
                end
            endcase
        end
    end

    // result of a string once its last byte is taken
    assign l_ok     = !n_failed && (n_phase == PH_DIGIT || n_phase == PH_TRAIL);
    assign l_mag    = dtti_pkg::CALC_BITS'(n_acc);
    assign l_signed = n_neg ? (~l_mag + 1'b1) : l_mag;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_ok    = r_out_ok;
        n_out_value = r_out_value;
        if (o_pop && i_head.last) begin
            n_out_valid = 1'b1;
            n_out_ok    = l_ok;
            n_out_value = l_ok ? l_signed[dtti_pkg::OUT_BITS-1:0] : '0;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // scan state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                if (i_head.last) begin
                    r_phase  <= PH_LEAD;
                    r_acc    <= '0;
                    r_neg    <= 1'b0;
                    r_failed <= 1'b0;
                end else begin
                    r_phase  <= n_phase;
                    r_acc    <= n_acc;
                    r_neg    <= n_neg;
                    r_failed <= n_failed;
                end
            end
        end
        r_out_ok    <= n_out_ok;
        r_out_value <= n_out_value;
    end

    assign o_out_valid    = r_out_valid;
    assign o_parse_ok     = r_out_ok;
    assign o_number_value = r_out_value;

`ifndef ASSERT_OFF
    // a failed parse always carries a zero value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_ok |-> r_out_value == '0)
        else $error("failed result with non-zero value");

    // the scan state is clear after a last byte
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_head.last |=> r_phase == PH_LEAD && r_acc == '0 && !r_neg && !r_failed)
        else $error("scan state not cleared after last byte");

    // no magnitude before the first digit
    a_acc_zero_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_LEAD || r_phase == PH_SIGN |-> r_acc == '0)
        else $error("accumulator set before any digit");

    // a failed string leaves the magnitude alone
    a_failed_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed && o_pop && !i_head.last |=> $stable(r_acc) && r_failed)
        else $error("accumulator moved after failure");
`endif

endmodule
